// ----- rtl/heightmap_bilinear_sampler_defines.svh -----
// assertion helpers used by the checker file
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent ends
`define HBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent ends
`define HBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hbs_pkg.sv -----
package hbs_pkg;

    // default geometry
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_FRAC_BITS  = 8;

    // field widths
    localparam int DIM_W    = 10;
    localparam int IDX_W    = 18;
    localparam int PIX_W    = 8;
    localparam int COORD_W  = 18;
    localparam int OUT_W    = 24;
    localparam int OUT_FRAC = 16;

    // register port
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // default bank depth, one of two banks
    localparam int RAM_DEF_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT / 2;

    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_SAMPLE = 1'b1
    } t_req;

    typedef enum logic {
        REG_MAP_WIDTH  = 1'b0,
        REG_MAP_HEIGHT = 1'b1
    } t_reg;

endpackage

// ----- rtl/hbs_ram.sv -----
module hbs_ram
    import hbs_pkg::*;
#(
    parameter int WIDTH = PIX_W,
    parameter int DEPTH = RAM_DEF_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered reads, held while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// ----- rtl/heightmap_bilinear_sampler.sv -----
// a sample request passes the stage registers in order, then the result register
// one request per cycle unless the result side stalls, writes and samples mixed;
//   each sample needs four pixels in one cycle, served by two address-parity banks with two read ports each
// a write request gives no result; a stall on the result side freezes only full stages
// reset (synchronous, active low) clears valid bits and the loaded flag and sets both
//   size registers to 1; the height store keeps its contents and needs no clearing pass
module heightmap_bilinear_sampler
    import hbs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_req_type,
    input  logic [IDX_W-1:0]          i_pixel_index,
    input  logic [PIX_W-1:0]          i_pixel_value,
    input  logic signed [COORD_W-1:0] i_x_coord,
    input  logic signed [COORD_W-1:0] i_z_coord,
    // result channel
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [OUT_W-1:0]          o_height_value,
    // register port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready
);

    // store geometry: flat row-major address, split by address parity
    localparam int STORE_D = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = $clog2(STORE_D);
    localparam int BANK_D  = STORE_D / 2;
    localparam int BAW     = AW - 1;
    localparam int IXW     = (IDX_W > AW) ? IDX_W : AW;
    localparam int AREA_W  = 2 * DIM_W;
    localparam int PW      = (AW > AREA_W) ? AW : AREA_W;
    localparam int CMPW    = (IXW > AREA_W) ? IXW : AREA_W;

    // coordinate and blend widths
    localparam int CW     = ((COORD_W > DIM_W + FRAC_BITS) ? COORD_W : DIM_W + FRAC_BITS) + 1;
    localparam int CLW    = DIM_W + FRAC_BITS;
    localparam int WT_W   = FRAC_BITS + 1;
    localparam int ROW_W  = PIX_W + FRAC_BITS;
    localparam int ACC_W  = PIX_W + 2 * FRAC_BITS;
    localparam int SH_W   = ACC_W + OUT_FRAC;
    localparam logic [WT_W-1:0] ONE = WT_W'(1 << FRAC_BITS);

    // clamp a signed fixed-point coordinate to [0, (dim-1).0]
    function automatic logic [CLW-1:0] clamp_coord(
        input logic signed [COORD_W-1:0] c,
        input logic [DIM_W-1:0]          dim
    );
        logic signed [CW-1:0] cs;
        logic signed [CW-1:0] top;
        logic [CW-1:0]        res;
        cs  = {{(CW - COORD_W){c[COORD_W-1]}}, c};
        top = $signed({{(CW - CLW){1'b0}}, dim - DIM_W'(1), {FRAC_BITS{1'b0}}});
        if (cs[CW-1]) begin
            res = '0;
        end else if (cs > top) begin
            res = top;
        end else begin
            res = cs;
        end
        return res[CLW-1:0];
    endfunction

    //------------------------------------------------------------------
    // configuration registers and derived sizes
    //------------------------------------------------------------------
    logic [DIM_W-1:0]  r_map_width;
    logic [DIM_W-1:0]  r_map_height;
    logic [DIM_W-1:0]  r_eff_w;
    logic [DIM_W-1:0]  r_eff_h;
    logic [DIM_W-1:0]  n_eff_w;
    logic [DIM_W-1:0]  n_eff_h;
    logic [AREA_W-1:0] r_area_m1;
    logic              cfg_wr;
    t_reg              cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = t_reg'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= DIM_W'(1);
            r_map_height <= DIM_W'(1);
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_MAP_WIDTH:  r_map_width  <= pwdata[DIM_W-1:0];
                REG_MAP_HEIGHT: r_map_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_MAP_WIDTH:  prdata = APB_DW'(r_map_width);
            REG_MAP_HEIGHT: prdata = APB_DW'(r_map_height);
            default:        prdata = '0;
        endcase
    end

    // zero acts as one, oversize acts as the store limit
    always_comb begin
        if (r_map_width == '0) begin
            n_eff_w = DIM_W'(1);
        end else if (32'(r_map_width) > 32'(MAX_WIDTH)) begin
            n_eff_w = DIM_W'(MAX_WIDTH);
        end else begin
            n_eff_w = r_map_width;
        end
        if (r_map_height == '0) begin
            n_eff_h = DIM_W'(1);
        end else if (32'(r_map_height) > 32'(MAX_HEIGHT)) begin
            n_eff_h = DIM_W'(MAX_HEIGHT);
        end else begin
            n_eff_h = r_map_height;
        end
    end

    // effective sizes are registered, and the area is registered from them; a request
    // already in a stage that uses them may still see the old sizes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w   <= DIM_W'(1);
            r_eff_h   <= DIM_W'(1);
            r_area_m1 <= '0;
        end else begin
            r_eff_w   <= n_eff_w;
            r_eff_h   <= n_eff_h;
            r_area_m1 <= AREA_W'(r_eff_w) * AREA_W'(r_eff_h) - AREA_W'(1);
        end
    end

    //------------------------------------------------------------------
    // stage load enables: a stage takes new content when it is empty or
    // its content moves on, so bubbles close up under a stall
    //------------------------------------------------------------------
    logic r_1_valid, r_2_valid, r_3_valid, r_4_valid, r_5_valid, r_o_valid;
    logic ld_1, ld_2, ld_3, ld_4, ld_5, ld_o;

    assign ld_o    = !r_o_valid || i_ready;
    assign ld_5    = !r_5_valid || ld_o;
    assign ld_4    = !r_4_valid || ld_5;
    assign ld_3    = !r_3_valid || ld_4;
    assign ld_2    = !r_2_valid || ld_3;
    assign ld_1    = !r_1_valid || ld_2;
    assign o_ready = ld_1;

    //------------------------------------------------------------------
    // stage 1: request register
    //------------------------------------------------------------------
    t_req                      r_1_type;
    logic [IDX_W-1:0]          r_1_idx;
    logic [PIX_W-1:0]          r_1_pix;
    logic signed [COORD_W-1:0] r_1_x;
    logic signed [COORD_W-1:0] r_1_z;

    always_ff @(posedge i_clk) begin
        if (ld_1) begin
            r_1_type <= t_req'(i_req_type);
            r_1_idx  <= i_pixel_index;
            r_1_pix  <= i_pixel_value;
            r_1_x    <= i_x_coord;
            r_1_z    <= i_z_coord;
        end
    end

    // clamp both coordinates to the grid edges
    logic [CLW-1:0] cl_x;
    logic [CLW-1:0] cl_z;

    assign cl_x = clamp_coord(r_1_x, r_eff_w);
    assign cl_z = clamp_coord(r_1_z, r_eff_h);

    //------------------------------------------------------------------
    // stage 2: integer cell and fractions
    //------------------------------------------------------------------
    t_req                 r_2_type;
    logic [IDX_W-1:0]     r_2_idx;
    logic [PIX_W-1:0]     r_2_pix;
    logic [DIM_W-1:0]     r_2_x0;
    logic [DIM_W-1:0]     r_2_z0;
    logic [FRAC_BITS-1:0] r_2_fx;
    logic [FRAC_BITS-1:0] r_2_fz;

    always_ff @(posedge i_clk) begin
        if (ld_2) begin
            r_2_type <= r_1_type;
            r_2_idx  <= r_1_idx;
            r_2_pix  <= r_1_pix;
            r_2_x0   <= cl_x[CLW-1:FRAC_BITS];
            r_2_z0   <= cl_z[CLW-1:FRAC_BITS];
            r_2_fx   <= cl_x[FRAC_BITS-1:0];
            r_2_fz   <= cl_z[FRAC_BITS-1:0];
        end
    end

    // far neighbours stop at the last column and row
    logic [DIM_W-1:0] nb_x1;
    logic [DIM_W-1:0] nb_z1;
    logic [PW-1:0]    row_base0;
    logic [PW-1:0]    row_base1;

    assign nb_x1 = (r_2_x0 == r_eff_w - DIM_W'(1)) ? r_2_x0 : r_2_x0 + DIM_W'(1);
    assign nb_z1 = (r_2_z0 == r_eff_h - DIM_W'(1)) ? r_2_z0 : r_2_z0 + DIM_W'(1);

    // row start addresses, one multiplier per row
    assign row_base0 = PW'(AREA_W'(r_2_z0) * AREA_W'(r_eff_w));
    assign row_base1 = PW'(AREA_W'(nb_z1) * AREA_W'(r_eff_w));

    //------------------------------------------------------------------
    // stage 3: addresses; memory reads and writes issue from here
    //------------------------------------------------------------------
    t_req                 r_3_type;
    logic [IDX_W-1:0]     r_3_idx;
    logic [PIX_W-1:0]     r_3_pix;
    logic [PW-1:0]        r_3_base0;
    logic [PW-1:0]        r_3_base1;
    logic [DIM_W-1:0]     r_3_x0;
    logic [DIM_W-1:0]     r_3_x1;
    logic [FRAC_BITS-1:0] r_3_fx;
    logic [FRAC_BITS-1:0] r_3_fz;

    always_ff @(posedge i_clk) begin
        if (ld_3) begin
            r_3_type  <= r_2_type;
            r_3_idx   <= r_2_idx;
            r_3_pix   <= r_2_pix;
            r_3_base0 <= row_base0;
            r_3_base1 <= row_base1;
            r_3_x0    <= r_2_x0;
            r_3_x1    <= nb_x1;
            r_3_fx    <= r_2_fx;
            r_3_fz    <= r_2_fz;
        end
    end

    logic [PW-1:0]  addr_00;
    logic [PW-1:0]  addr_01;
    logic [PW-1:0]  addr_10;
    logic [PW-1:0]  addr_11;
    logic [BAW-1:0] even_ra0;
    logic [BAW-1:0] even_ra1;
    logic [BAW-1:0] odd_ra0;
    logic [BAW-1:0] odd_ra1;

    assign addr_00 = r_3_base0 + PW'(r_3_x0);
    assign addr_01 = r_3_base0 + PW'(r_3_x1);
    assign addr_10 = r_3_base1 + PW'(r_3_x0);
    assign addr_11 = r_3_base1 + PW'(r_3_x1);

    // the two pixels of a row are equal or adjacent, so each bank serves
    // at most one of them; the same holds for the lower row
    assign even_ra0 = addr_00[0] ? addr_01[AW-1:1] : addr_00[AW-1:1];
    assign odd_ra0  = addr_00[0] ? addr_00[AW-1:1] : addr_01[AW-1:1];
    assign even_ra1 = addr_10[0] ? addr_11[AW-1:1] : addr_10[AW-1:1];
    assign odd_ra1  = addr_10[0] ? addr_10[AW-1:1] : addr_11[AW-1:1];

    // pixel writes take effect as the request leaves this stage, in order
    // with the reads of the samples around it
    logic           wr_go;
    logic [IXW-1:0] wr_idx;
    logic           wr_in_store;
    logic           we_even;
    logic           we_odd;
    logic           r_loaded;

    assign wr_go       = r_3_valid && (r_3_type == REQ_WRITE) && ld_4;
    assign wr_idx      = IXW'(r_3_idx);
    // one extra bit so a store size of a full power of two compares right
    assign wr_in_store = (IXW + 1)'(wr_idx) < (IXW + 1)'(STORE_D);
    assign we_even     = wr_go && wr_in_store && !wr_idx[0];
    assign we_odd      = wr_go && wr_in_store && wr_idx[0];

    // last pixel marks the map loaded, pixel 0 unloaded; last pixel wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
        end else if (wr_go) begin
            if (CMPW'(r_3_idx) == CMPW'(r_area_m1)) begin
                r_loaded <= 1'b1;
            end else if (r_3_idx == '0) begin
                r_loaded <= 1'b0;
            end
        end
    end

    logic [PIX_W-1:0] even_rd0;
    logic [PIX_W-1:0] even_rd1;
    logic [PIX_W-1:0] odd_rd0;
    logic [PIX_W-1:0] odd_rd1;

    hbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (BANK_D)
    ) u_bank_even (
        .i_clk    (i_clk),
        .i_we     (we_even),
        .i_waddr  (wr_idx[AW-1:1]),
        .i_wdata  (r_3_pix),
        .i_re     (ld_4),
        .i_raddr0 (even_ra0),
        .i_raddr1 (even_ra1),
        .o_rdata0 (even_rd0),
        .o_rdata1 (even_rd1)
    );

    hbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (BANK_D)
    ) u_bank_odd (
        .i_clk    (i_clk),
        .i_we     (we_odd),
        .i_waddr  (wr_idx[AW-1:1]),
        .i_wdata  (r_3_pix),
        .i_re     (ld_4),
        .i_raddr0 (odd_ra0),
        .i_raddr1 (odd_ra1),
        .o_rdata0 (odd_rd0),
        .o_rdata1 (odd_rd1)
    );

    //------------------------------------------------------------------
    // stage 4: memory data; only samples travel on from here
    //------------------------------------------------------------------
    logic                 r_4_loaded;
    logic [3:0]           r_4_par;
    logic [FRAC_BITS-1:0] r_4_fx;
    logic [FRAC_BITS-1:0] r_4_fz;

    always_ff @(posedge i_clk) begin
        if (ld_4) begin
            r_4_loaded <= r_loaded;
            r_4_par    <= {addr_11[0], addr_10[0], addr_01[0], addr_00[0]};
            r_4_fx     <= r_3_fx;
            r_4_fz     <= r_3_fz;
        end
    end

    logic [PIX_W-1:0] px_00;
    logic [PIX_W-1:0] px_01;
    logic [PIX_W-1:0] px_10;
    logic [PIX_W-1:0] px_11;
    logic [WT_W-1:0]  wx_hi;
    logic [WT_W-1:0]  wx_lo;
    logic [ROW_W-1:0] row_top;
    logic [ROW_W-1:0] row_bot;

    // route each bank output back to its neighbour by address parity
    assign px_00 = r_4_par[0] ? odd_rd0 : even_rd0;
    assign px_01 = r_4_par[1] ? odd_rd0 : even_rd0;
    assign px_10 = r_4_par[2] ? odd_rd1 : even_rd1;
    assign px_11 = r_4_par[3] ? odd_rd1 : even_rd1;

    // horizontal blend of each row
    assign wx_hi   = WT_W'(r_4_fx);
    assign wx_lo   = ONE - wx_hi;
    assign row_top = ROW_W'(px_00) * ROW_W'(wx_lo) + ROW_W'(px_01) * ROW_W'(wx_hi);
    assign row_bot = ROW_W'(px_10) * ROW_W'(wx_lo) + ROW_W'(px_11) * ROW_W'(wx_hi);

    //------------------------------------------------------------------
    // stage 5: row blends
    //------------------------------------------------------------------
    logic                 r_5_loaded;
    logic [ROW_W-1:0]     r_5_top;
    logic [ROW_W-1:0]     r_5_bot;
    logic [FRAC_BITS-1:0] r_5_fz;

    always_ff @(posedge i_clk) begin
        if (ld_5) begin
            r_5_loaded <= r_4_loaded;
            r_5_top    <= row_top;
            r_5_bot    <= row_bot;
            r_5_fz     <= r_4_fz;
        end
    end

    logic [WT_W-1:0]  wz_hi;
    logic [WT_W-1:0]  wz_lo;
    logic [ACC_W-1:0] blend;
    logic [SH_W-1:0]  blend_q16;
    logic [OUT_W-1:0] n_height;

    // vertical blend, then rescale to 16 fraction bits (truncating)
    assign wz_hi     = WT_W'(r_5_fz);
    assign wz_lo     = ONE - wz_hi;
    assign blend     = ACC_W'(r_5_top) * ACC_W'(wz_lo) + ACC_W'(r_5_bot) * ACC_W'(wz_hi);
    assign blend_q16 = {blend, {OUT_FRAC{1'b0}}} >> (2 * FRAC_BITS);
    // an unloaded map samples as zero
    assign n_height  = r_5_loaded ? blend_q16[OUT_W-1:0] : '0;

    //------------------------------------------------------------------
    // result register
    //------------------------------------------------------------------
    logic [OUT_W-1:0] r_o_height;

    always_ff @(posedge i_clk) begin
        if (ld_o) begin
            r_o_height <= n_height;
        end
    end

    // valid bits; a write request drops out as it leaves stage 3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_1_valid <= 1'b0;
            r_2_valid <= 1'b0;
            r_3_valid <= 1'b0;
            r_4_valid <= 1'b0;
            r_5_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (ld_1) begin
                r_1_valid <= i_valid;
            end
            if (ld_2) begin
                r_2_valid <= r_1_valid;
            end
            if (ld_3) begin
                r_3_valid <= r_2_valid;
            end
            if (ld_4) begin
                r_4_valid <= r_3_valid && (r_3_type == REQ_SAMPLE);
            end
            if (ld_5) begin
                r_5_valid <= r_4_valid;
            end
            if (ld_o) begin
                r_o_valid <= r_5_valid;
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_height_value = r_o_height;

endmodule

// ----- rtl/hbs_checker.sv -----
`include "heightmap_bilinear_sampler_defines.svh"

module hbs_checker
    import hbs_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              i_req_type,
    input logic              o_valid,
    input logic              i_ready,
    input logic [OUT_W-1:0]  o_height_value,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata,
    input logic              pready
);

    logic req_acc;
    logic req_sample;
    logic wr_width;
    logic rd_width;

    assign req_acc    = i_valid && o_ready;
    assign req_sample = req_acc && (t_req'(i_req_type) == REQ_SAMPLE);
    assign wr_width   = psel && penable && pwrite && pready
                        && (t_reg'(paddr[APB_AW-1:2]) == REG_MAP_WIDTH);
    assign rd_width   = psel && !pwrite && (t_reg'(paddr[APB_AW-1:2]) == REG_MAP_WIDTH);

    // a waiting result holds
    `HBS_ASSERT_NEXT(a_result_hold, o_valid && !i_ready, o_valid && $stable(o_height_value), "result dropped or changed while stalled")

    // a sample with no back-pressure reaches the result output
    `HBS_ASSERT_NEXT(a_sample_latency, (req_sample && i_ready) ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready, o_valid, "sample result missing")

    // with no requests and a free output the pipeline drains empty
    `HBS_ASSERT_NEXT(a_no_spurious, (!req_acc && i_ready) ##1 (!req_acc && i_ready) ##1 (!req_acc && i_ready) ##1 (!req_acc && i_ready) ##1 (!req_acc && i_ready) ##1 (!req_acc && i_ready), !o_valid, "result without a sample request")

    // a width write reads back at once
    `HBS_ASSERT_NOW(a_cfg_readback, wr_width ##1 rd_width, prdata[DIM_W-1:0] == $past(pwdata[DIM_W-1:0]), "width register readback mismatch")

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (.*);
